// ===== hw/rtl/htct_pkg.sv =====
// ---------------------------------------------------------------------------
// htct_pkg: shared types and constants of the hashed target clue table
// Opcodes, status codes, the queued work item and the back-end states.
// ---------------------------------------------------------------------------
package htct_pkg;

  localparam int unsigned DefHashBits = 12;
  localparam int unsigned DefWays     = 4;
  localparam int unsigned DefClues    = 8;
  localparam int unsigned MaxHashBits = 16;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned ScoreW      = 7;
  localparam int unsigned CountOutW   = 4;
  localparam int unsigned BucketOutW  = 12;
  localparam logic [6:0]  ScoreMax    = 7'd100;
  localparam logic [6:0]  DefaultScoreRst = 7'd60;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_INVALID     = 3'd2,
    ST_BUCKET_FULL = 3'd3,
    ST_SLOTS_FULL  = 3'd4,
    ST_SCORE_RANGE = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_DEFAULT_SCORE = 1'd0,
    REG_INVALID_ID    = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_EXEC
  } back_state_e;

  // One word as it travels from the front end to the back end.
  typedef struct packed {
    logic [1:0]             op;
    logic [KeyW-1:0]        key;
    logic [31:0]            number;
    logic [31:0]            flags;
    logic [31:0]            score;
    logic [MaxHashBits-1:0] hash_top;
    logic                   bad_id;
  } item_t;

endpackage

// ===== hw/rtl/htct_front.sv =====
// ---------------------------------------------------------------------------
// htct_front: input stage of the hashed target clue table
// Takes a word, hashes the key in two add steps and checks the id.
// ---------------------------------------------------------------------------
module htct_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                op_i,
  input  logic [63:0]               target_key_i,
  input  logic [31:0]               clue_number_i,
  input  logic [31:0]               clue_flags_i,
  input  logic [31:0]               clue_score_i,
  input  logic [63:0]               invalid_id_i,
  output logic                      push_o,
  output htct_pkg::item_t           item_o,
  input  logic                      full_i
);

  logic            hold_q;
  htct_pkg::item_t item_q;
  logic [63:0]     part_a_q, part_b_q;
  logic [63:0]     hash;
  logic            accept;

  assign in_stall_o = hold_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = hold_q & ~full_i;

  // Multiply by 0x9E37FFFFFFFC0001 as shifted terms in two partial sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (accept) begin
      hold_q <= 1'b1;
    end else if (push_o) begin
      hold_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      part_a_q      <= target_key_i - (target_key_i << 18) + (target_key_i << 54);
      part_b_q      <= (target_key_i << 61) + (target_key_i << 63)
                       - (target_key_i << 51) - (target_key_i << 57);
      item_q.op     <= op_i;
      item_q.key    <= target_key_i;
      item_q.number <= clue_number_i;
      item_q.flags  <= clue_flags_i;
      item_q.score  <= clue_score_i;
      item_q.bad_id <= (target_key_i == invalid_id_i);
      item_q.hash_top <= '0;
    end
  end

  assign hash = part_a_q + part_b_q;

  always_comb begin
    item_o          = item_q;
    item_o.hash_top = hash[63 -: htct_pkg::MaxHashBits];
  end

endmodule

// ===== hw/rtl/htct_fifo.sv =====
// ---------------------------------------------------------------------------
// htct_fifo: two-word queue between the front end and the back end
// Lets either side stall without holding up the other.
// ---------------------------------------------------------------------------
module htct_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  htct_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output htct_pkg::item_t item_o
);

  htct_pkg::item_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/htct_back.sv =====
// ---------------------------------------------------------------------------
// htct_back: table engine of the hashed target clue table
// Reads a bucket row, matches ways, updates entry and clue slot, reports.
// ---------------------------------------------------------------------------
module htct_back #(
  parameter int unsigned HASH_BITS = htct_pkg::DefHashBits,
  parameter int unsigned WAYS      = htct_pkg::DefWays,
  parameter int unsigned CLUES     = htct_pkg::DefClues
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  htct_pkg::item_t item_i,
  output logic            pop_o,
  input  logic [6:0]      default_score_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      status_o,
  output logic            found_o,
  output logic            created_o,
  output logic [6:0]      entry_score_o,
  output logic [3:0]      clue_count_o,
  output logic [11:0]     bucket_index_o
);

  localparam int unsigned NB   = 1 << HASH_BITS;
  localparam int unsigned CW   = $clog2(CLUES + 1);
  localparam int unsigned WIW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SAW  = $clog2(NB * WAYS * CLUES);
  localparam int unsigned SDW  = 32 + 32 + 7;

  // Bucket-row stores; one read and one write address per cycle.
  logic [WAYS-1:0]           val_mem   [NB];
  logic [WAYS-1:0][6:0]      score_mem [NB];
  logic [WAYS-1:0][CW-1:0]   cnt_mem   [NB];
  logic [WAYS-1:0][63:0]     key_mem   [NB];
  logic [SDW-1:0]            slot_mem  [NB * WAYS * CLUES];

  htct_pkg::back_state_e state_q, state_d;
  htct_pkg::item_t       cur_q, cur_d;
  logic [HASH_BITS-1:0]  clr_idx_q, clr_idx_d;

  logic [WAYS-1:0]         rd_val_q;
  logic [WAYS-1:0][6:0]    rd_score_q;
  logic [WAYS-1:0][CW-1:0] rd_cnt_q;
  logic [WAYS-1:0][63:0]   rd_key_q;

  logic                    out_valid_q, out_valid_d;
  logic [2:0]              status_q, status_d;
  logic                    found_q, found_d, created_q, created_d;
  logic [6:0]              tscore_q, tscore_d;
  logic [CW-1:0]           tcnt_q, tcnt_d;
  logic [11:0]             bucket_out_q, bucket_out_d;

  logic [HASH_BITS-1:0]    bucket, cur_bucket, wr_addr;
  logic [15:0]             bucket_wide;
  logic                    row_we, key_we, slot_we;
  logic [WAYS-1:0]         wr_val;
  logic [WAYS-1:0][6:0]    wr_score;
  logic [WAYS-1:0][CW-1:0] wr_cnt;
  logic [WAYS-1:0][63:0]   wr_key;
  logic [SAW-1:0]          slot_addr;
  logic [SDW-1:0]          slot_data;

  logic                    hit, free;
  logic [WIW-1:0]          hit_way, free_way, sel_way;
  logic [6:0]              e_score;
  logic [CW-1:0]           e_cnt;
  logic                    score_ok;
  logic [31:0]             cnt_ext;

  assign bucket     = item_i.hash_top[htct_pkg::MaxHashBits-1 -: HASH_BITS];
  assign cur_bucket = cur_q.hash_top[htct_pkg::MaxHashBits-1 -: HASH_BITS];
  assign wr_addr    = (state_q == htct_pkg::BK_CLEAR) ? clr_idx_q : cur_bucket;
  assign score_ok   = ~cur_q.score[31] && (cur_q.score <= 32'(htct_pkg::ScoreMax));

  always_comb begin
    bucket_wide = '0;
    bucket_wide[HASH_BITS-1:0] = bucket;
  end

  // Way match and first free way over the registered row.
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_val_q[w] && rd_key_q[w] == cur_q.key) begin
        hit     = 1'b1;
        hit_way = WIW'(w);
      end
      if (!rd_val_q[w]) begin
        free     = 1'b1;
        free_way = WIW'(w);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    clr_idx_d    = clr_idx_q;
    pop_o        = 1'b0;
    out_valid_d  = out_valid_q & out_stall_i;
    status_d     = status_q;
    found_d      = found_q;
    created_d    = created_q;
    tscore_d     = tscore_q;
    tcnt_d       = tcnt_q;
    bucket_out_d = bucket_out_q;
    row_we       = 1'b0;
    key_we       = 1'b0;
    slot_we      = 1'b0;
    wr_val       = rd_val_q;
    wr_score     = rd_score_q;
    wr_cnt       = rd_cnt_q;
    wr_key       = rd_key_q;
    sel_way      = hit ? hit_way : free_way;
    e_score      = hit ? rd_score_q[sel_way] : default_score_i;
    e_cnt        = hit ? rd_cnt_q[sel_way] : '0;
    slot_addr    = SAW'((32'(cur_bucket) * WAYS + 32'(sel_way)) * CLUES + 32'(e_cnt));
    slot_data    = {cur_q.number, cur_q.flags, cur_q.score[6:0]};

    case (state_q)
      htct_pkg::BK_CLEAR: begin
        row_we    = 1'b1;
        wr_val    = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (&clr_idx_q) begin
          state_d = htct_pkg::BK_IDLE;
        end
      end
      htct_pkg::BK_IDLE: begin
        if (!empty_i && !out_valid_q) begin
          pop_o        = 1'b1;
          cur_d        = item_i;
          status_d     = htct_pkg::ST_OK;
          found_d      = 1'b0;
          created_d    = 1'b0;
          tscore_d     = '0;
          tcnt_d       = '0;
          bucket_out_d = bucket_wide[11:0];
          if (item_i.op == htct_pkg::OP_CLEAR) begin
            out_valid_d  = 1'b1;
            bucket_out_d = '0;
            clr_idx_d    = '0;
            state_d      = htct_pkg::BK_CLEAR;
          end else if (item_i.op == htct_pkg::OP_NONE) begin
            out_valid_d  = 1'b1;
            bucket_out_d = '0;
          end else if (item_i.bad_id) begin
            out_valid_d = 1'b1;
            status_d    = htct_pkg::ST_INVALID;
          end else begin
            state_d = htct_pkg::BK_READ;
          end
        end
      end
      htct_pkg::BK_READ: begin
        state_d = htct_pkg::BK_EXEC;
      end
      htct_pkg::BK_EXEC: begin
        out_valid_d = 1'b1;
        state_d     = htct_pkg::BK_IDLE;
        if (cur_q.op == htct_pkg::OP_QUERY) begin
          if (hit) begin
            found_d  = 1'b1;
            tscore_d = rd_score_q[hit_way];
            tcnt_d   = rd_cnt_q[hit_way];
          end else begin
            status_d = htct_pkg::ST_NOT_FOUND;
          end
        end else if (!hit && !free) begin
          status_d = htct_pkg::ST_BUCKET_FULL;
        end else begin
          found_d   = 1'b1;
          created_d = ~hit;
          tscore_d  = e_score;
          tcnt_d    = e_cnt;
          wr_val[sel_way]   = 1'b1;
          wr_score[sel_way] = e_score;
          wr_cnt[sel_way]   = e_cnt;
          wr_key[sel_way]   = cur_q.key;
          row_we = ~hit;
          key_we = ~hit;
          if (32'(e_cnt) == CLUES) begin
            status_d = htct_pkg::ST_SLOTS_FULL;
          end else if (!score_ok) begin
            status_d = htct_pkg::ST_SCORE_RANGE;
          end else begin
            slot_we         = 1'b1;
            row_we          = 1'b1;
            wr_cnt[sel_way] = e_cnt + 1'b1;
            tcnt_d          = e_cnt + 1'b1;
          end
        end
      end
      default: begin
        state_d = htct_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htct_pkg::BK_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    status_q     <= status_d;
    found_q      <= found_d;
    created_q    <= created_d;
    tscore_q     <= tscore_d;
    tcnt_q       <= tcnt_d;
    bucket_out_q <= bucket_out_d;
  end

  always_ff @(posedge clk_i) begin
    rd_val_q   <= val_mem[cur_bucket];
    rd_score_q <= score_mem[cur_bucket];
    rd_cnt_q   <= cnt_mem[cur_bucket];
    rd_key_q   <= key_mem[cur_bucket];
    if (row_we) begin
      val_mem[wr_addr]   <= wr_val;
      score_mem[wr_addr] <= wr_score;
      cnt_mem[wr_addr]   <= wr_cnt;
    end
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (slot_we) begin
      slot_mem[slot_addr] <= slot_data;
    end
  end

  assign cnt_ext        = 32'(tcnt_q);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign created_o      = created_q;
  assign entry_score_o  = tscore_q;
  assign clue_count_o   = cnt_ext[3:0];
  assign bucket_index_o = bucket_out_q;

endmodule

// ===== hw/rtl/hashed_target_clue_table_unit.sv =====
// ---------------------------------------------------------------------------
// hashed_target_clue_table_unit: hashed table of targets with clue slots
// Add, query and clear on a bucketed table keyed by a multiplicative hash.
// ---------------------------------------------------------------------------
// An accepted add or query word passes the front-end register, the queue, and
//   the back end's pop, row-read and update states before out_valid_o; invalid-id,
//   clear and unused-op words are reported from the pop state. The back end takes
//   a new word only after the result of the last one has been taken.
// Reset and the clear op sweep the bucket rows, one per cycle; words queue
//   meanwhile, configuration writes are taken as ever.
module hashed_target_clue_table_unit #(
  parameter int unsigned HASH_BITS = htct_pkg::DefHashBits,
  parameter int unsigned WAYS      = htct_pkg::DefWays,
  parameter int unsigned CLUES     = htct_pkg::DefClues
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [63:0]        target_key_i,
  input  logic [31:0]        clue_number_i,
  input  logic signed [31:0] clue_flags_i,
  input  logic signed [31:0] clue_score_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic               found_o,
  output logic               created_o,
  output logic [6:0]         entry_score_o,
  output logic [3:0]         clue_count_o,
  output logic [11:0]        bucket_index_o
);

  logic [6:0]      default_score_q;
  logic [63:0]     invalid_id_q;
  logic            push, full, pop, empty;
  htct_pkg::item_t front_item, queue_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_score_q <= htct_pkg::DefaultScoreRst;
      invalid_id_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        htct_pkg::REG_DEFAULT_SCORE: default_score_q <= cfg_data_i[6:0];
        htct_pkg::REG_INVALID_ID:    invalid_id_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  htct_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .target_key_i,
    .clue_number_i,
    .clue_flags_i  (clue_flags_i),
    .clue_score_i  (clue_score_i),
    .invalid_id_i  (invalid_id_q),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  htct_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  htct_back #(
    .HASH_BITS (HASH_BITS),
    .WAYS      (WAYS),
    .CLUES     (CLUES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .empty_i         (empty),
    .item_i          (queue_item),
    .pop_o           (pop),
    .default_score_i (default_score_q),
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .found_o,
    .created_o,
    .entry_score_o,
    .clue_count_o,
    .bucket_index_o
  );

endmodule
